[hw/rtl/b58dec_pkg.sv]
// Shared types, codes and the alphabet lookup for the base58 decoder.
// No dependencies; used by base58_decoder.
`default_nettype none

package b58dec_pkg;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last_symbol;
  } sym_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [5:0] byte_index;
    logic [2:0] status;
    logic       end_of_run;
  } res_t;

  // eight accumulator bytes per memory word, byte 0 least significant
  typedef logic [7:0][7:0] word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_CHECK,
    S_SCAN,
    S_FAIL,
    S_EMIT
  } b58_state_t;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_LEN  = 3'd1;
  localparam logic [2:0] ST_INVALID  = 3'd2;
  localparam logic [2:0] ST_OVERFLOW = 3'd3;
  localparam logic [2:0] ST_MISMATCH = 3'd4;

  localparam logic [1:0] REG_OUTPUT_BYTES = 2'd0;
  localparam logic [1:0] REG_MAX_CHARS    = 2'd1;

  localparam logic [6:0] OUTPUT_BYTES_RST = 7'd32;
  localparam logic [6:0] MAX_CHARS_RST    = 7'd44;
  localparam logic [6:0] MAX_CHARS_CAP    = 7'd126;
  localparam logic [7:0] ONE_CHAR         = 8'h31;
  localparam logic [7:0] NO_DIGIT         = 8'hFF;
  localparam logic [7:0] RADIX            = 8'd58;

  localparam logic [8*58-1:0] ALPHABET =
    "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

  function automatic logic [7:0] b58_digit(input logic [7:0] sym);
    logic [7:0] d;
    d = NO_DIGIT;
    for (int i = 0; i < 58; i++) begin
      if (ALPHABET[8*(57-i) +: 8] == sym) begin
        d = 8'(i);
      end
    end
    return d;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/base58_decoder.sv]
// base58_decoder: one base58 character per input transfer, decoded bytes out.
// Accumulator lives in a word memory (8 bytes per word). Depends on b58dec_pkg.
//
// Input channel sym_valid/sym_stall/sym_data carries one character and a last
// flag. Output channel res_valid/res_stall/res_data carries decoded bytes,
// most significant first, or a single status item on failure. cfg_valid/
// cfg_ready/cfg_index/cfg_value writes output_bytes (index 0) or max_chars
// (index 1); it is ready only between characters.
// Each character is accepted in S_IDLE, then S_MUL does one read-multiply-write
// step per memory word over W = ceil(output_bytes/8) words, each with an 8-byte
// x58 carry chain. An invalid character, or any character after a latched
// error, skips the multiply. The last character then passes a check state and
// a leading-zero scan of the W words, then gives one result per cycle while the
// output register is free; a failure is one status item from check or scan.
// Results sit in an output register; a valid result holds while res_stall is high,
// and a decoder with the next result ready waits with sym_stall high.
// Reset (rst, synchronous) returns output_bytes to 32, max_chars to 44 and
// clears the string state at once; per-word valid bits stand in for clearing
// the memory, so no clearing pass is needed after reset or per string.
`default_nettype none

module base58_decoder #(
  parameter int MAX_BYTES = 64
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 sym_valid,
  output logic                sym_stall,
  input  b58dec_pkg::sym_t    sym_data,
  output logic                res_valid,
  input  wire                 res_stall,
  output b58dec_pkg::res_t    res_data,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire  [1:0]          cfg_index,
  input  wire  [6:0]          cfg_value
);

  localparam int LIM = (MAX_BYTES < 64) ? MAX_BYTES : 64;
  localparam int NW  = (LIM + 7) / 8;
  localparam int AW  = (NW > 1) ? $clog2(NW) : 1;

  b58dec_pkg::b58_state_t state, state_next;

  logic [6:0]          cfg_ob, cfg_mc;
  logic [6:0]          char_count, char_count_next;
  logic [6:0]          lones, lones_next;
  logic                in_prefix, in_prefix_next;
  logic [2:0]          first_err, first_err_next;
  logic                is_last, is_last_next;
  logic [AW-1:0]       wptr, wptr_next;
  logic [5:0]          carry, carry_next;
  logic [6:0]          lz, lz_next;
  logic                zero_run, zero_run_next;
  logic [5:0]          bpos, bpos_next;
  logic [2:0]          err_code, err_code_next;
  logic [NW-1:0]       valid_bits, valid_bits_next;
  logic                res_valid_next;
  b58dec_pkg::res_t    res_data_next;

  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_raddr;
  b58dec_pkg::word_t   acc_mem [NW];
  b58dec_pkg::word_t   rd_data, rd_word, mul_word;
  logic                rd_vld;

  logic [6:0]          ob_eff, mc_eff, mc_p1;
  logic [5:0]          top;
  logic [AW-1:0]       top_word;
  logic [7:0]          dig;
  logic [5:0]          carry_out;
  logic [3:0]          scan_cnt;
  logic                scan_zr;
  logic [6:0]          lz_sum;
  logic [5:0]          bpos_dec;
  logic                res_free;

  always_comb begin
    if (cfg_ob == 7'd0) begin
      ob_eff = 7'd1;
    end else if (cfg_ob > 7'(LIM)) begin
      ob_eff = 7'(LIM);
    end else begin
      ob_eff = cfg_ob;
    end
  end

  assign mc_eff   = (cfg_mc > b58dec_pkg::MAX_CHARS_CAP) ? b58dec_pkg::MAX_CHARS_CAP : cfg_mc;
  assign mc_p1    = mc_eff + 7'd1;
  assign top      = 6'(ob_eff - 7'd1);
  assign top_word = top[AW+2:3];
  assign dig      = b58dec_pkg::b58_digit(sym_data.symbol);
  assign rd_word  = rd_vld ? rd_data : '0;
  assign lz_sum   = lz + 7'(scan_cnt);
  assign bpos_dec = bpos - 6'd1;
  assign res_free = !res_valid || !res_stall;

  assign sym_stall = (state != b58dec_pkg::S_IDLE);
  assign cfg_ready = (state == b58dec_pkg::S_IDLE);

  // one word of acc = acc * 58 + carry, bytes at or above output_bytes untouched
  always_comb begin
    logic [13:0] v;
    logic [5:0]  c;
    c        = carry;
    mul_word = rd_word;
    v        = '0;
    for (int j = 0; j < 8; j++) begin
      if (7'({wptr, 3'(j)}) < ob_eff) begin
        v           = 14'(rd_word[j]) * 14'(b58dec_pkg::RADIX) + 14'(c);
        mul_word[j] = v[7:0];
        c           = v[13:8];
      end
    end
    carry_out = c;
  end

  // leading zero bytes of one word, top byte first
  always_comb begin
    logic       zr;
    logic [3:0] cnt;
    zr  = zero_run;
    cnt = '0;
    for (int j = 7; j >= 0; j--) begin
      if ((7'({wptr, 3'(j)}) < ob_eff) && zr) begin
        if (rd_word[j] == 8'd0) begin
          cnt = cnt + 4'd1;
        end else begin
          zr = 1'b0;
        end
      end
    end
    scan_cnt = cnt;
    scan_zr  = zr;
  end

  always_comb begin
    state_next      = state;
    char_count_next = char_count;
    lones_next      = lones;
    in_prefix_next  = in_prefix;
    first_err_next  = first_err;
    is_last_next    = is_last;
    wptr_next       = wptr;
    carry_next      = carry;
    lz_next         = lz;
    zero_run_next   = zero_run;
    bpos_next       = bpos;
    err_code_next   = err_code;
    valid_bits_next = valid_bits;
    res_valid_next  = res_valid && res_stall;
    res_data_next   = res_data;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    mem_raddr       = wptr;

    unique case (state)
      b58dec_pkg::S_IDLE: begin
        if (sym_valid) begin
          if (char_count < mc_p1) begin
            char_count_next = char_count + 7'd1;
          end
          if (in_prefix && (sym_data.symbol == b58dec_pkg::ONE_CHAR)) begin
            if (lones != 7'h7F) begin
              lones_next = lones + 7'd1;
            end
          end else begin
            in_prefix_next = 1'b0;
          end
          is_last_next = sym_data.last_symbol;
          state_next   = sym_data.last_symbol ? b58dec_pkg::S_CHECK : b58dec_pkg::S_IDLE;
          if (first_err == b58dec_pkg::ST_OK) begin
            if (dig == b58dec_pkg::NO_DIGIT) begin
              first_err_next = b58dec_pkg::ST_INVALID;
            end else begin
              carry_next = dig[5:0];
              wptr_next  = '0;
              mem_re     = 1'b1;
              mem_raddr  = '0;
              state_next = b58dec_pkg::S_MUL;
            end
          end
        end
      end

      b58dec_pkg::S_MUL: begin
        mem_we                = 1'b1;
        valid_bits_next[wptr] = 1'b1;
        if (wptr == top_word) begin
          if (carry_out != 6'd0) begin
            first_err_next = b58dec_pkg::ST_OVERFLOW;
          end
          state_next = is_last ? b58dec_pkg::S_CHECK : b58dec_pkg::S_IDLE;
        end else begin
          wptr_next  = wptr + 1'b1;
          carry_next = carry_out;
          mem_re     = 1'b1;
          mem_raddr  = wptr + 1'b1;
        end
      end

      b58dec_pkg::S_CHECK: begin
        if ((char_count < ob_eff) || (char_count > mc_eff)) begin
          err_code_next = b58dec_pkg::ST_BAD_LEN;
          state_next    = b58dec_pkg::S_FAIL;
        end else if (first_err != b58dec_pkg::ST_OK) begin
          err_code_next = first_err;
          state_next    = b58dec_pkg::S_FAIL;
        end else begin
          wptr_next     = top_word;
          lz_next       = '0;
          zero_run_next = 1'b1;
          mem_re        = 1'b1;
          mem_raddr     = top_word;
          state_next    = b58dec_pkg::S_SCAN;
        end
      end

      b58dec_pkg::S_SCAN: begin
        lz_next       = lz_sum;
        zero_run_next = scan_zr;
        if (wptr == '0) begin
          if (lz_sum != lones) begin
            err_code_next = b58dec_pkg::ST_MISMATCH;
            state_next    = b58dec_pkg::S_FAIL;
          end else begin
            bpos_next  = top;
            mem_re     = 1'b1;
            mem_raddr  = top_word;
            state_next = b58dec_pkg::S_EMIT;
          end
        end else begin
          wptr_next = wptr - 1'b1;
          mem_re    = 1'b1;
          mem_raddr = wptr - 1'b1;
        end
      end

      b58dec_pkg::S_FAIL: begin
        if (res_free) begin
          res_valid_next           = 1'b1;
          res_data_next.data_byte  = 8'd0;
          res_data_next.byte_index = 6'd0;
          res_data_next.status     = err_code;
          res_data_next.end_of_run = 1'b1;
          state_next               = b58dec_pkg::S_IDLE;
        end
      end

      b58dec_pkg::S_EMIT: begin
        if (res_free) begin
          res_valid_next           = 1'b1;
          res_data_next.data_byte  = rd_word[bpos[2:0]];
          res_data_next.byte_index = top - bpos;
          res_data_next.status     = b58dec_pkg::ST_OK;
          res_data_next.end_of_run = (bpos == 6'd0);
          if (bpos == 6'd0) begin
            state_next = b58dec_pkg::S_IDLE;
          end else begin
            bpos_next = bpos_dec;
            if (bpos[2:0] == 3'd0) begin
              mem_re    = 1'b1;
              mem_raddr = bpos_dec[AW+2:3];
            end
          end
        end
      end

      default: begin
        state_next = b58dec_pkg::S_IDLE;
      end
    endcase

    // string done: drop per-string state
    if (((state == b58dec_pkg::S_FAIL) || (state == b58dec_pkg::S_EMIT)) &&
        (state_next == b58dec_pkg::S_IDLE)) begin
      char_count_next = '0;
      lones_next      = '0;
      in_prefix_next  = 1'b1;
      first_err_next  = b58dec_pkg::ST_OK;
      valid_bits_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= b58dec_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count <= '0;
      lones      <= '0;
      in_prefix  <= 1'b1;
      first_err  <= b58dec_pkg::ST_OK;
      valid_bits <= '0;
      res_valid  <= 1'b0;
    end else begin
      char_count <= char_count_next;
      lones      <= lones_next;
      in_prefix  <= in_prefix_next;
      first_err  <= first_err_next;
      valid_bits <= valid_bits_next;
      res_valid  <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    is_last  <= is_last_next;
    wptr     <= wptr_next;
    carry    <= carry_next;
    lz       <= lz_next;
    zero_run <= zero_run_next;
    bpos     <= bpos_next;
    err_code <= err_code_next;
    res_data <= res_data_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_ob <= b58dec_pkg::OUTPUT_BYTES_RST;
      cfg_mc <= b58dec_pkg::MAX_CHARS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        b58dec_pkg::REG_OUTPUT_BYTES: cfg_ob <= cfg_value;
        b58dec_pkg::REG_MAX_CHARS:    cfg_mc <= cfg_value;
        default: begin
        end
      endcase
    end
  end

  // accumulator memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      acc_mem[wptr] <= mul_word;
    end
    if (mem_re) begin
      rd_data <= acc_mem[mem_raddr];
      rd_vld  <= valid_bits[mem_raddr];
    end
  end

`ifndef SYNTH
  a_fail_single: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res_data.status != b58dec_pkg::ST_OK)) |-> res_data.end_of_run)
    else $error("failure item without end_of_run");

  a_mul_range: assert property (@(posedge clk) disable iff (rst)
    (state == b58dec_pkg::S_MUL) |-> (wptr <= top_word))
    else $error("multiply pass beyond top word");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_stall && res_data.end_of_run &&
     (res_data.status == b58dec_pkg::ST_OK)) |-> (res_data.byte_index == top))
    else $error("successful run ends at wrong byte index");

  a_err_code: assert property (@(posedge clk) disable iff (rst)
    (first_err == b58dec_pkg::ST_OK) || (first_err == b58dec_pkg::ST_INVALID) ||
    (first_err == b58dec_pkg::ST_OVERFLOW))
    else $error("latched error code out of set");

  a_emit_len: assert property (@(posedge clk) disable iff (rst)
    (state == b58dec_pkg::S_EMIT) |-> ((char_count >= ob_eff) && (char_count <= mc_eff)))
    else $error("emitting bytes for a string of bad length");
`endif

endmodule

`default_nettype wire
